FILE: hw/rtl/fccl_pkg.sv
// shared types and constants for the fat cluster chain lookup block
package fccl_pkg;

    localparam logic [1:0] FAT_KIND_12 = 2'd0;
    localparam logic [1:0] FAT_KIND_16 = 2'd1;
    localparam logic [1:0] FAT_KIND_32 = 2'd2;

    localparam logic [1:0] REG_FAT_KIND     = 2'd0;
    localparam logic [1:0] REG_TABLE_START  = 2'd1;
    localparam logic [1:0] REG_SECTOR_LOG2  = 2'd2;

    localparam logic [1:0] RES_LOCATION = 2'd0;
    localparam logic [1:0] RES_DECODED  = 2'd1;
    localparam logic [1:0] RES_CROSSES  = 2'd2;

    localparam logic [0:0] CMD_LOCATE = 1'b0;
    localparam logic [0:0] CMD_BYTE   = 1'b1;

    localparam logic [3:0] SECTOR_LOG2_MIN = 4'd9;
    localparam logic [3:0] SECTOR_LOG2_MAX = 4'd12;

    // sector size select: 0 for 512 bytes up to 3 for 4096 bytes
    typedef logic [1:0] size_sel_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] start;
        size_sel_t   size_sel;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] sector;
        logic [11:0] offset;
        logic [27:0] next_cluster;
        logic        chain_end;
        logic        erase;
    } result_t;

    function automatic logic [12:0] size_last(input size_sel_t sel);
        logic [12:0] r;
        unique case (sel)
            2'd0: r = 13'd511;
            2'd1: r = 13'd1023;
            2'd2: r = 13'd2047;
            2'd3: r = 13'd4095;
            default: r = 13'd511;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/fccl_locate.sv
// entry position, fat sector and in-sector offset for a locate beat
module fccl_locate (
    input  fccl_pkg::cfg_t cfg,
    input  logic [27:0]    cluster_number,
    output logic [31:0]    sector_number,
    output logic [11:0]    byte_offset
);
    import fccl_pkg::*;

    logic [29:0] pos;
    logic [29:0] sector_rel;
    logic [11:0] offset_mask;

    always_comb begin
        unique case (cfg.kind)
            FAT_KIND_32: pos = {cluster_number, 2'b00};
            FAT_KIND_16: pos = {1'b0, cluster_number, 1'b0};
            default:     pos = {2'b00, cluster_number} + {3'b000, cluster_number[27:1]};
        endcase
    end

    always_comb begin
        unique case (cfg.size_sel)
            2'd0: begin
                sector_rel  = pos >> 9;
                offset_mask = 12'h1FF;
            end
            2'd1: begin
                sector_rel  = pos >> 10;
                offset_mask = 12'h3FF;
            end
            2'd2: begin
                sector_rel  = pos >> 11;
                offset_mask = 12'h7FF;
            end
            default: begin
                sector_rel  = pos >> 12;
                offset_mask = 12'hFFF;
            end
        endcase
    end

    assign sector_number = cfg.start + {2'b00, sector_rel};
    assign byte_offset   = pos[11:0] & offset_mask;

endmodule

FILE: hw/rtl/fccl_entry.sv
// lookup state, entry byte capture and entry decode for sector byte beats
module fccl_entry (
    input  logic              aclk,
    input  logic              aresetn,
    input  fccl_pkg::cfg_t    cfg,
    input  logic              locate_accept,
    input  logic              byte_accept,
    input  logic              cluster_odd,
    input  logic              delete_request,
    input  logic [11:0]       locate_offset,
    input  logic [7:0]        sector_byte,
    output logic              byte_result_valid,
    output fccl_pkg::result_t byte_result
);
    import fccl_pkg::*;

    logic        odd_reg,    odd_next;
    logic [11:0] offset_reg, offset_next;
    logic [12:0] count_reg,  count_next;
    logic [27:0] entry_reg,  entry_next;
    logic        erase_reg,  erase_next;
    logic        armed_reg,  armed_next;

    logic [12:0] last_idx;
    logic        in_range;
    logic [1:0]  rel_idx;
    logic [27:0] byte_shifted;
    logic [27:0] entry_merged;
    logic        done;
    logic        crosses;
    logic [27:0] value;
    logic        chain_end;
    logic [7:0]  b0;
    logic [7:0]  b1;

    assign last_idx = {1'b0, offset_reg} + ((cfg.kind == FAT_KIND_32) ? 13'd3 : 13'd1);
    assign in_range = (count_reg >= {1'b0, offset_reg}) && (count_reg <= last_idx);
    assign rel_idx  = count_reg[1:0] - offset_reg[1:0];
    assign byte_shifted = {20'd0, sector_byte} << {rel_idx, 3'b000};
    assign entry_merged = in_range ? (entry_reg | byte_shifted) : entry_reg;

    assign done    = armed_reg && (count_reg == last_idx);
    assign crosses = armed_reg && !done && (count_reg >= size_last(cfg.size_sel));

    assign b0 = entry_merged[7:0];
    assign b1 = entry_merged[15:8];

    always_comb begin
        unique case (cfg.kind)
            FAT_KIND_32: begin
                value     = entry_merged;
                chain_end = &entry_merged[27:3];
            end
            FAT_KIND_16: begin
                value     = {12'd0, entry_merged[15:0]};
                chain_end = &entry_merged[15:3];
            end
            default: begin
                value     = odd_reg ? {16'd0, b1, b0[7:4]} : {16'd0, b1[3:0], b0};
                chain_end = &value[11:3];
            end
        endcase
    end

    always_comb begin
        byte_result_valid = byte_accept && (done || crosses);
        byte_result.sector = '0;
        byte_result.offset = offset_reg;
        if (done) begin
            byte_result.kind         = RES_DECODED;
            byte_result.next_cluster = value;
            byte_result.chain_end    = chain_end;
            byte_result.erase        = erase_reg;
        end else begin
            byte_result.kind         = RES_CROSSES;
            byte_result.next_cluster = '0;
            byte_result.chain_end    = 1'b0;
            byte_result.erase        = 1'b0;
        end
    end

    always_comb begin
        odd_next    = odd_reg;
        offset_next = offset_reg;
        count_next  = count_reg;
        entry_next  = entry_reg;
        erase_next  = erase_reg;
        armed_next  = armed_reg;
        if (locate_accept) begin
            odd_next    = cluster_odd;
            offset_next = locate_offset;
            count_next  = '0;
            entry_next  = '0;
            erase_next  = delete_request;
            armed_next  = 1'b1;
        end else if (byte_accept && armed_reg) begin
            entry_next = entry_merged;
            count_next = count_reg + 13'd1;
            if (done || crosses) begin
                armed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            odd_reg    <= 1'b0;
            offset_reg <= '0;
            count_reg  <= '0;
            entry_reg  <= '0;
            erase_reg  <= 1'b0;
            armed_reg  <= 1'b0;
        end else begin
            odd_reg    <= odd_next;
            offset_reg <= offset_next;
            count_reg  <= count_next;
            entry_reg  <= entry_next;
            erase_reg  <= erase_next;
            armed_reg  <= armed_next;
        end
    end

endmodule

FILE: hw/rtl/fat_cluster_chain_lookup.sv
// top level of the fat cluster chain lookup block
// Takes one beat per clock cycle while s_ready is high. A locate beat gives a location result in the
// cycle after its acceptance; sector byte beats give a decoded entry or a sector-crossing result on
// the beat that completes the entry or reaches the sector end, and nothing otherwise. Each beat's
// work is a single pass of logic into one output register, which holds a result while the input
// side keeps accepting as long as that register is empty or is being drained in the same cycle.
// fat_kind 3 acts as FAT32 and sector_size_log2 is clamped to 9..12; both are used live on every beat.
module fat_cluster_chain_lookup (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [27:0] s_cluster_number,
    input  logic        s_delete_request,
    input  logic [7:0]  s_sector_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [31:0] m_sector_number,
    output logic [11:0] m_byte_offset,
    output logic [27:0] m_next_cluster,
    output logic        m_chain_end,
    output logic        m_erase_entry
);
    import fccl_pkg::*;

    logic [1:0]  fat_kind_reg;
    logic [31:0] table_start_reg;
    logic [3:0]  size_log2_reg;
    cfg_t        cfg;
    logic [3:0]  size_clamped;

    logic        accept;
    logic        locate_accept;
    logic        byte_accept;
    logic [31:0] loc_sector;
    logic [11:0] loc_offset;
    logic        byte_result_valid;
    result_t     byte_result;
    result_t     loc_result;

    logic        out_valid_reg, out_valid_next;
    result_t     out_reg,       out_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fat_kind_reg    <= FAT_KIND_12;
            table_start_reg <= '0;
            size_log2_reg   <= SECTOR_LOG2_MIN;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FAT_KIND:    fat_kind_reg    <= cfg_wdata[1:0];
                REG_TABLE_START: table_start_reg <= cfg_wdata;
                REG_SECTOR_LOG2: size_log2_reg   <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (size_log2_reg < SECTOR_LOG2_MIN) begin
            size_clamped = SECTOR_LOG2_MIN;
        end else if (size_log2_reg > SECTOR_LOG2_MAX) begin
            size_clamped = SECTOR_LOG2_MAX;
        end else begin
            size_clamped = size_log2_reg;
        end
    end

    assign cfg.kind     = (fat_kind_reg == FAT_KIND_12 || fat_kind_reg == FAT_KIND_16)
                          ? fat_kind_reg : FAT_KIND_32;
    assign cfg.start    = table_start_reg;
    assign cfg.size_sel = 2'(size_clamped - SECTOR_LOG2_MIN);

    assign s_ready       = !out_valid_reg || m_ready;
    assign accept        = s_valid && s_ready;
    assign locate_accept = accept && (s_command == CMD_LOCATE);
    assign byte_accept   = accept && (s_command == CMD_BYTE);

    fccl_locate u_locate (
        .cfg            (cfg),
        .cluster_number (s_cluster_number),
        .sector_number  (loc_sector),
        .byte_offset    (loc_offset)
    );

    fccl_entry u_entry (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .locate_accept     (locate_accept),
        .byte_accept       (byte_accept),
        .cluster_odd       (s_cluster_number[0]),
        .delete_request    (s_delete_request),
        .locate_offset     (loc_offset),
        .sector_byte       (s_sector_byte),
        .byte_result_valid (byte_result_valid),
        .byte_result       (byte_result)
    );

    always_comb begin
        loc_result.kind         = RES_LOCATION;
        loc_result.sector       = loc_sector;
        loc_result.offset       = loc_offset;
        loc_result.next_cluster = '0;
        loc_result.chain_end    = 1'b0;
        loc_result.erase        = 1'b0;
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        if (locate_accept) begin
            out_valid_next = 1'b1;
            out_next       = loc_result;
        end else if (byte_result_valid) begin
            out_valid_next = 1'b1;
            out_next       = byte_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_result_kind   = out_reg.kind;
    assign m_sector_number = out_reg.sector;
    assign m_byte_offset   = out_reg.offset;
    assign m_next_cluster  = out_reg.next_cluster;
    assign m_chain_end     = out_reg.chain_end;
    assign m_erase_entry   = out_reg.erase;

endmodule
